[hw/rtl/drum_pkg.sv]
// Package for the delta-R unique matcher: widths, codes, entry layout, sequencer states.
// No dependencies; used by drum_ram users and delta_r_unique_matcher_core.
package drum_pkg;

  localparam int MAX_REFS   = 64;
  localparam int REF_IDX_W  = $clog2(MAX_REFS);
  localparam int REF_CNT_W  = $clog2(MAX_REFS + 1);

  localparam int PT_W       = 16;
  localparam int ETA_W      = 11;
  localparam int PHI_W      = 10;
  localparam int PID_W      = 24;
  localparam int LIMIT_W    = 23;
  localparam int MATCH_W    = 7;
  localparam int DETA_W     = ETA_W + 1;
  localparam int DETA_SQ_W  = 22;  // 2047^2 fits
  localparam int DPHI_SQ_W  = 19;  // 512^2 fits
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // input modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_ID     = 1'b1;

  localparam logic [LIMIT_W-1:0]    DIST_LIMIT_RST = 23'd2391;
  localparam logic [CFG_DATA_W-1:0] REQ_ID_RST     = 24'd0;

  localparam logic signed [MATCH_W-1:0] MATCH_NONE  = -7'sd1;
  localparam logic signed [MATCH_W-1:0] MATCH_AMBIG = -7'sd2;

  typedef struct packed {
    logic                    usable;
    logic [PID_W-1:0]        id_mag;
    logic signed [ETA_W-1:0] eta;
    logic [PHI_W-1:0]        phi;
  } ref_entry_t;

  localparam int ENTRY_W = $bits(ref_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } drum_state_t;

endpackage

[hw/rtl/drum_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module drum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/delta_r_unique_matcher_core.sv]
// Top level of the delta-R unique matcher: reference table in drum_ram, scan pipeline.
// Depends on drum_pkg and drum_ram.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | in_mode, in_transverse_momentum, ...    | start high while busy low
//  result  | out_match_index                         | out_strobe, one cycle
//  config  | cfg_index, cfg_data                     | cfg_valid and cfg_ready
//
// Clear and append leave busy low. A query holds busy high while it scans the table; no
// entry is read when the query pt is unusable or the table is empty. Otherwise there is
// one table read per cycle through the single RAM read port, then the distance unit.
// out_strobe rises on the cycle busy falls. Reset (rst_n, synchronous) empties the table
// and loads register defaults; the RAM is not cleared.
// The receiver cannot stall; cfg_ready is always high.
module delta_r_unique_matcher_core
  import drum_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_mode,
  input  logic [PT_W-1:0]               in_transverse_momentum,
  input  logic                          in_pt_invalid,
  input  logic signed [ETA_W-1:0]       in_pseudorapidity,
  input  logic [PHI_W-1:0]              in_azimuth,
  input  logic signed [PID_W-1:0]       in_particle_id,
  output logic                          out_strobe,
  output logic signed [MATCH_W-1:0]     out_match_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  drum_state_t state_r, state_nxt;

  logic [LIMIT_W-1:0]    dist_limit_r, dist_limit_nxt;
  logic [CFG_DATA_W-1:0] req_id_r, req_id_nxt;
  logic [REF_CNT_W-1:0]  ref_count_r, ref_count_nxt;
  logic [REF_CNT_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [REF_CNT_W-1:0]  scan_end_r, scan_end_nxt;

  logic signed [ETA_W-1:0] q_eta_r, q_eta_nxt;
  logic [PHI_W-1:0]        q_phi_r, q_phi_nxt;

  logic                 v1_r, v1_nxt;
  logic [REF_IDX_W-1:0] idx1_r, idx1_nxt;
  logic                 v2_r, v2_nxt;
  logic [REF_IDX_W-1:0] idx2_r, idx2_nxt;
  logic                 ok2_r, ok2_nxt;
  logic [DETA_SQ_W-1:0] deta_sq_r, deta_sq_nxt;
  logic [DPHI_SQ_W-1:0] dphi_sq_r, dphi_sq_nxt;

  logic                 found_r, found_nxt;
  logic                 ambig_r, ambig_nxt;
  logic [REF_IDX_W-1:0] hit_idx_r, hit_idx_nxt;

  logic                        out_strobe_r, out_strobe_nxt;
  logic signed [MATCH_W-1:0]   out_index_r, out_index_nxt;

  logic       accept;
  logic       in_usable;
  logic       wr_en;
  logic       rd_en;
  ref_entry_t wr_entry;
  ref_entry_t rd_entry;
  logic [ENTRY_W-1:0] rd_data;

  logic signed [DETA_W-1:0]    deta;
  logic signed [PHI_W-1:0]     dphi;
  logic signed [2*DETA_W-1:0]  deta_prod;
  logic signed [2*PHI_W-1:0]   dphi_prod;
  logic [LIMIT_W-1:0]          dist_sum;
  logic                        hit;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_usable = (in_transverse_momentum != '0) && !in_pt_invalid;

  assign wr_en = accept && (in_mode == MODE_APPEND) &&
                 (ref_count_r < REF_CNT_W'(MAX_REFS));

  always_comb begin
    wr_entry.usable = in_usable;
    wr_entry.id_mag = in_particle_id[PID_W-1] ? (~in_particle_id + 1'b1) : in_particle_id;
    wr_entry.eta    = in_pseudorapidity;
    wr_entry.phi    = in_azimuth;
  end

  assign rd_en = (state_r == ST_SCAN) && (rd_addr_r < scan_end_r);

  drum_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_REFS)
  ) u_ref_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ref_count_r[REF_IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r[REF_IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_entry = ref_entry_t'(rd_data);

  // distance unit, stage one: differences and squares
  assign deta      = DETA_W'(q_eta_r) - DETA_W'(rd_entry.eta);
  assign dphi      = q_phi_r - rd_entry.phi;  // wraps mod 1024, read as signed
  assign deta_prod = deta * deta;
  assign dphi_prod = dphi * dphi;

  // stage two: sum and compare
  assign dist_sum = {1'b0, deta_sq_r} + {4'b0, dphi_sq_r};
  assign hit      = v2_r && ok2_r && (dist_sum < dist_limit_r);

  always_comb begin
    state_nxt      = state_r;
    dist_limit_nxt = dist_limit_r;
    req_id_nxt     = req_id_r;
    ref_count_nxt  = ref_count_r;
    rd_addr_nxt    = rd_addr_r;
    scan_end_nxt   = scan_end_r;
    q_eta_nxt      = q_eta_r;
    q_phi_nxt      = q_phi_r;
    v1_nxt         = rd_en;
    idx1_nxt       = rd_addr_r[REF_IDX_W-1:0];
    v2_nxt         = v1_r;
    idx2_nxt       = idx1_r;
    ok2_nxt        = rd_entry.usable &&
                     ((req_id_r == '0) || (rd_entry.id_mag == req_id_r));
    deta_sq_nxt    = deta_prod[DETA_SQ_W-1:0];
    dphi_sq_nxt    = dphi_prod[DPHI_SQ_W-1:0];
    found_nxt      = found_r;
    ambig_nxt      = ambig_r;
    hit_idx_nxt    = hit_idx_r;
    out_strobe_nxt = 1'b0;
    out_index_nxt  = out_index_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIST_LIMIT: dist_limit_nxt = cfg_data[LIMIT_W-1:0];
        CFG_REQ_ID:     req_id_nxt     = cfg_data;
        default:        ;
      endcase
    end

    if (rd_en) begin
      rd_addr_nxt = rd_addr_r + 1'b1;
    end

    if (hit) begin
      if (found_r) begin
        ambig_nxt = 1'b1;
      end else begin
        found_nxt   = 1'b1;
        hit_idx_nxt = idx2_r;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_CLEAR:  ref_count_nxt = '0;
            MODE_APPEND: begin
              if (wr_en) begin
                ref_count_nxt = ref_count_r + 1'b1;
              end
            end
            MODE_QUERY: begin
              state_nxt    = ST_SCAN;
              rd_addr_nxt  = '0;
              scan_end_nxt = in_usable ? ref_count_r : '0;
              q_eta_nxt    = in_pseudorapidity;
              q_phi_nxt    = in_azimuth;
              found_nxt    = 1'b0;
              ambig_nxt    = 1'b0;
            end
            MODE_UNUSED: ;
            default:     ;
          endcase
        end
      end
      ST_SCAN: begin
        // pipeline drained and all entries issued
        if (!rd_en && !v1_r && !v2_r) begin
          state_nxt      = ST_IDLE;
          out_strobe_nxt = 1'b1;
          priority if (ambig_r) begin
            out_index_nxt = MATCH_AMBIG;
          end else if (found_r) begin
            out_index_nxt = MATCH_W'(hit_idx_r);
          end else begin
            out_index_nxt = MATCH_NONE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dist_limit_r <= DIST_LIMIT_RST;
      req_id_r     <= REQ_ID_RST;
      ref_count_r  <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      found_r      <= 1'b0;
      ambig_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dist_limit_r <= dist_limit_nxt;
      req_id_r     <= req_id_nxt;
      ref_count_r  <= ref_count_nxt;
      v1_r         <= v1_nxt;
      v2_r         <= v2_nxt;
      found_r      <= found_nxt;
      ambig_r      <= ambig_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    scan_end_r  <= scan_end_nxt;
    q_eta_r     <= q_eta_nxt;
    q_phi_r     <= q_phi_nxt;
    idx1_r      <= idx1_nxt;
    idx2_r      <= idx2_nxt;
    ok2_r       <= ok2_nxt;
    deta_sq_r   <= deta_sq_nxt;
    dphi_sq_r   <= dphi_sq_nxt;
    hit_idx_r   <= hit_idx_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_match_index = out_index_r;

endmodule

[bench/tb_delta_r_unique_matcher_core.sv]
// Testbench for delta_r_unique_matcher_core: directed and random clear/append/query traffic,
// checked against a predictor of the delta-R unique match. Depends on drum_pkg and the RTL.
`timescale 1ns / 1ps

module tb_delta_r_unique_matcher_core;
  import drum_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = MAX_REFS + 16;

  typedef struct {
    logic [1:0]              mode;
    logic [PT_W-1:0]         pt;
    logic                    pt_invalid;
    logic signed [ETA_W-1:0] eta;
    logic [PHI_W-1:0]        phi;
    logic signed [PID_W-1:0] pid;
  } match_item_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                in_mode = MODE_UNUSED;
  logic [PT_W-1:0]           in_transverse_momentum = '0;
  logic                      in_pt_invalid = 1'b0;
  logic signed [ETA_W-1:0]   in_pseudorapidity = '0;
  logic [PHI_W-1:0]          in_azimuth = '0;
  logic signed [PID_W-1:0]   in_particle_id = '0;
  logic                      out_strobe;
  logic signed [MATCH_W-1:0] out_match_index;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_DIST_LIMIT;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  // predictor state: register copies and reference table
  logic [LIMIT_W-1:0]        dist_limit = DIST_LIMIT_RST;
  logic [CFG_DATA_W-1:0]     req_id = REQ_ID_RST;
  logic signed [ETA_W-1:0]   tbl_eta [MAX_REFS];
  logic [PHI_W-1:0]          tbl_phi [MAX_REFS];
  logic [PID_W-1:0]          tbl_id_mag [MAX_REFS];
  logic                      tbl_usable [MAX_REFS];
  int                        stored_count = 0;

  logic signed [MATCH_W-1:0] pending_match_idx [$];
  int                        mismatch_count = 0;
  int                        items_accepted = 0;
  int                        cycle_count = 0;

  delta_r_unique_matcher_core i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_mode                (in_mode),
    .in_transverse_momentum (in_transverse_momentum),
    .in_pt_invalid          (in_pt_invalid),
    .in_pseudorapidity      (in_pseudorapidity),
    .in_azimuth             (in_azimuth),
    .in_particle_id         (in_particle_id),
    .out_strobe             (out_strobe),
    .out_match_index        (out_match_index),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** delta_r_unique_matcher_core: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [MATCH_W-1:0] predict_match_index(
    input logic [PT_W-1:0]         pt,
    input logic                    pt_invalid,
    input logic signed [ETA_W-1:0] eta,
    input logic [PHI_W-1:0]        phi
  );
    int               found;
    int               deta;
    int               dphi;
    logic [PHI_W-1:0] dphi_raw;
    found = -1;
    if (pt != '0 && !pt_invalid) begin
      for (int j = 0; j < stored_count; j++) begin
        if (!tbl_usable[j]) continue;
        deta = int'(eta) - int'(tbl_eta[j]);
        dphi_raw = phi - tbl_phi[j];
        dphi = int'(dphi_raw);
        if (dphi >= 512) dphi -= 1024;  // fold wrapped phi into -512..511
        if (deta * deta + dphi * dphi >= int'(dist_limit)) continue;
        if (req_id != '0 && tbl_id_mag[j] != req_id) continue;
        if (found >= 0) begin
          found = -2;
          break;
        end
        found = j;
      end
    end
    return found[MATCH_W-1:0];
  endfunction

  // checks results, tracks register writes and accepted transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (pending_match_idx.size() == 0) begin
          $error("match_index: expected none, got %0d", out_match_index);
          mismatch_count++;
        end else if (out_match_index !== pending_match_idx[0]) begin
          $error("match_index: expected %0d, got %0d", pending_match_idx[0], out_match_index);
          mismatch_count++;
          void'(pending_match_idx.pop_front());
        end else begin
          void'(pending_match_idx.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIST_LIMIT: dist_limit = cfg_data[LIMIT_W-1:0];
          CFG_REQ_ID:     req_id = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_mode)
          MODE_CLEAR: stored_count = 0;
          MODE_APPEND: begin
            if (stored_count < MAX_REFS) begin
              tbl_eta[stored_count] = in_pseudorapidity;
              tbl_phi[stored_count] = in_azimuth;
              tbl_id_mag[stored_count] = in_particle_id[PID_W-1] ? -in_particle_id
                                                                   : in_particle_id;
              tbl_usable[stored_count] = in_transverse_momentum != '0 && !in_pt_invalid;
              stored_count++;
            end
          end
          MODE_QUERY: pending_match_idx = {pending_match_idx, predict_match_index(
            in_transverse_momentum, in_pt_invalid, in_pseudorapidity, in_azimuth)};
          default: ;
        endcase
      end
    end
  end

  function automatic match_item_t mk_item(
    input logic [1:0]              mode,
    input logic [PT_W-1:0]         pt,
    input logic                    pt_invalid,
    input logic signed [ETA_W-1:0] eta,
    input logic [PHI_W-1:0]        phi,
    input logic signed [PID_W-1:0] pid
  );
    match_item_t it;
    it.mode = mode;
    it.pt = pt;
    it.pt_invalid = pt_invalid;
    it.eta = eta;
    it.phi = phi;
    it.pid = pid;
    return it;
  endfunction

  task automatic send_item(input match_item_t it);
    start <= 1'b1;
    in_mode <= it.mode;
    in_transverse_momentum <= it.pt;
    in_pt_invalid <= it.pt_invalid;
    in_pseudorapidity <= it.eta;
    in_azimuth <= it.phi;
    in_particle_id <= it.pid;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.mode != MODE_UNUSED) items_accepted++;
  endtask

  task automatic idle_gap(input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, 70))
        @(posedge clk);
    end
  endtask

  // waits first for a pending start to be taken, so that its transaction is already queued
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_match_idx.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_basic_matching();
    send_item(mk_item(MODE_QUERY, 100, 0, 0, 0, 0));             // empty table
    send_item(mk_item(MODE_APPEND, 1, 0, 0, 0, -24'sd8388608));  // entry 0
    send_item(mk_item(MODE_APPEND, 0, 0, 0, 0, 5));              // zero pt, stored as unusable
    send_item(mk_item(MODE_APPEND, 65535, 1, 0, 0, 5));          // invalid pt, stored as unusable
    send_item(mk_item(MODE_QUERY, 65535, 0, 0, 0, 0));
    send_item(mk_item(MODE_QUERY, 0, 0, 0, 0, 0));
    send_item(mk_item(MODE_QUERY, 1, 1, 0, 0, 0));
    send_item(mk_item(MODE_APPEND, 7, 0, -11'sd1024, 1023, 24'sd8388607));
    send_item(mk_item(MODE_QUERY, 3, 0, -11'sd1024, 0, 0));      // phi wraps to distance 1
    send_item(mk_item(MODE_QUERY, 3, 0, 11'sd1023, 512, 0));     // dphi folds to -512
    send_item(mk_item(MODE_UNUSED, 65535, 1, -11'sd1024, 1023, -24'sd1));
    send_item(mk_item(MODE_APPEND, 9, 0, 30, 1000, 0));
    send_item(mk_item(MODE_QUERY, 2, 0, 0, 0, 0));               // two hits: ambiguous
  endtask

  task automatic test_register_extremes();
    drain_results();
    write_register(CFG_DIST_LIMIT, 24'd0);
    send_item(mk_item(MODE_QUERY, 2, 0, 0, 0, 0));
    drain_results();
    write_register(CFG_DIST_LIMIT, 24'd8388607);
    write_register(CFG_REQ_ID, 24'd8388608);  // magnitude of the most negative id
    send_item(mk_item(MODE_QUERY, 2, 0, 11'sd1023, 512, 0));
    drain_results();
    write_register(CFG_REQ_ID, 24'hFFFFFF);
    send_item(mk_item(MODE_QUERY, 2, 0, 11'sd1023, 512, 0));
    drain_results();
    write_register(CFG_REQ_ID, 24'd0);
    send_item(mk_item(MODE_QUERY, 2, 0, 11'sd1023, 512, 0));
  endtask

  task automatic test_clear();
    send_item(mk_item(MODE_CLEAR, 0, 0, 0, 0, 0));
    send_item(mk_item(MODE_QUERY, 2, 0, 0, 0, 0));
  endtask

  // clear, a clustered fill (now and then past capacity), then queries near the entries
  task automatic random_sequence(input int idle_pct, input logic [CFG_DATA_W-1:0] pool_id);
    match_item_t             it;
    logic signed [ETA_W-1:0] near_eta [$];
    logic [PHI_W-1:0]        near_phi [$];
    logic signed [ETA_W-1:0] base_eta;
    logic [PHI_W-1:0]        base_phi;
    int                      n_fill;
    int                      n_query;
    int                      k;
    int                      off;
    base_eta = ETA_W'($urandom());
    base_phi = PHI_W'($urandom());
    n_fill = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
    n_query = $urandom_range(1, 6);
    send_item(mk_item(MODE_CLEAR, PT_W'($urandom()), 1'($urandom()), ETA_W'($urandom()),
                      PHI_W'($urandom()), PID_W'($urandom())));
    for (int i = 0; i < n_fill; i++) begin
      idle_gap(idle_pct);
      it.mode = MODE_APPEND;
      it.pt = ($urandom_range(0, 7) == 0) ? '0 : PT_W'($urandom_range(1, 65535));
      it.pt_invalid = ($urandom_range(0, 9) == 0);
      off = $urandom_range(0, 120);
      off = int'(base_eta) + off - 60;
      it.eta = off[ETA_W-1:0];
      it.phi = base_phi + PHI_W'($urandom_range(0, 120)) - PHI_W'(60);
      if (pool_id != '0 && $urandom_range(0, 1))
        it.pid = $urandom_range(0, 1) ? pool_id : -pool_id;
      else
        it.pid = PID_W'($urandom());
      near_eta = {near_eta, it.eta};
      near_phi = {near_phi, it.phi};
      send_item(it);
    end
    for (int i = 0; i < n_query; i++) begin
      idle_gap(idle_pct);
      it.mode = MODE_QUERY;
      it.pt = ($urandom_range(0, 9) == 0) ? '0 : PT_W'($urandom_range(1, 65535));
      it.pt_invalid = ($urandom_range(0, 11) == 0);
      it.pid = PID_W'($urandom());
      if (near_eta.size() == 0 || $urandom_range(0, 3) == 0) begin
        it.eta = ETA_W'($urandom());
        it.phi = PHI_W'($urandom());
      end else begin
        k = $urandom_range(0, near_eta.size() - 1);
        off = $urandom_range(0, 80);
        off = int'(near_eta[k]) + off - 40;
        it.eta = off[ETA_W-1:0];
        it.phi = near_phi[k] + PHI_W'($urandom_range(0, 80)) - PHI_W'(40);
      end
      send_item(it);
    end
  endtask

  task automatic run_random_phase(input int idle_pct, input logic [LIMIT_W-1:0] limit,
                                  input logic [CFG_DATA_W-1:0] id, input int n_items);
    int target;
    drain_results();
    write_register(CFG_DIST_LIMIT, CFG_DATA_W'(limit));
    write_register(CFG_REQ_ID, id);
    target = items_accepted + n_items;
    while (items_accepted < target) begin
      case ($urandom_range(0, 9))
        0: send_item(mk_item(2'($urandom()), PT_W'($urandom()), 1'($urandom()),
                             ETA_W'($urandom()), PHI_W'($urandom()), PID_W'($urandom())));
        1: if ($urandom_range(0, 3) == 0) drain_results();
        default: random_sequence(idle_pct, id);
      endcase
      idle_gap(idle_pct);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_matching();
    test_register_extremes();
    test_clear();
    run_random_phase(0, DIST_LIMIT_RST, 24'd0, 250);
    run_random_phase(46, LIMIT_W'($urandom_range(0, 5000)), 24'd0, 250);
    run_random_phase(13, LIMIT_W'($urandom_range(1, 20000)),
                     CFG_DATA_W'($urandom_range(1, 8388608)), 200);
    run_random_phase(0, LIMIT_W'($urandom()), CFG_DATA_W'($urandom_range(1, 3)), 100);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_match_idx.size() == 0) begin
      $display("** delta_r_unique_matcher_core: PASSED **");
    end else begin
      $display("** delta_r_unique_matcher_core: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/drum_pkg.sv
hw/rtl/drum_ram.sv
hw/rtl/delta_r_unique_matcher_core.sv
bench/tb_delta_r_unique_matcher_core.sv
